>>> design/ps2_mouse_packet_tracker_macros.svh
// Assertion helpers shared by the PS/2 mouse tracker.
`ifndef PS2_MOUSE_PACKET_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PS2MT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PS2MT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ps2mt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2mt_pkg;

	localparam int CFG_W       = 13;
	localparam int OUT_COORD_W = 12;
	localparam int MV_W        = 10;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	// Register decode on paddr[2].
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

	// Header byte bit positions.
	localparam int HDR_LEFT   = 0;
	localparam int HDR_RIGHT  = 1;
	localparam int HDR_MIDDLE = 2;
	localparam int HDR_SYNC   = 3;
	localparam int HDR_X_SIGN = 4;
	localparam int HDR_Y_SIGN = 5;
	localparam int HDR_X_OVF  = 6;
	localparam int HDR_Y_OVF  = 7;

	localparam logic signed [MV_W-1:0] OVF_STEP = 10'sd255;

	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_XMOVE  = 4'b0100,
		PH_YMOVE  = 4'b1000
	} phase_t;

	// A negative move byte b is worth -((256-b) mod 256), which is b-256 for
	// nonzero b and zero for b equal to zero.
	function automatic logic signed [MV_W-1:0] movement(input logic [7:0] b,
			input logic neg, input logic ovf);
		logic signed [MV_W-1:0] v;
		logic signed [MV_W-1:0] extra;
		extra = ovf ? OVF_STEP : '0;
		if (!neg) begin
			v = signed'({2'b00, b}) + extra;
		end else begin
			v = ((b == 8'd0) ? '0 : signed'({2'b11, b})) - extra;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

>>> design/ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ps2_mouse_packet_tracker_macros.svh"

// PS/2 mouse packet tracker. Takes one mouse byte per beat on the input channel and
// gives one result beat (cursor position and button bits) for every completed
// three-byte packet. The first byte after reset is dropped, and a header byte with
// bit 3 clear is dropped to regain framing. A byte may be accepted in every cycle
// while input ready is high. A third byte's result is registered in the output
// register, and the third byte waits in the input register while the previous
// result is not taken. Input ready drops only while the input register holds
// a third byte and the output register still holds a result not yet taken. Screen
// sizes are written over the APB port (width at 0x0, height at 0x4); the user must
// write them only while no byte is in flight, which the block does not enforce.
module ps2_mouse_packet_tracker #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ps2mt_pkg::APB_AW-1:0]   paddr,
	input  wire logic [ps2mt_pkg::APB_DW-1:0]   pwdata,
	output logic      [ps2mt_pkg::APB_DW-1:0]   prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     rx_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [ps2mt_pkg::OUT_COORD_W-1:0]   cursor_x,
	output logic [ps2mt_pkg::OUT_COORD_W-1:0]   cursor_y,
	output logic                                left_pressed,
	output logic                                right_pressed,
	output logic                                middle_pressed
);
	import ps2mt_pkg::*;

	// Signed working width: holds position plus or minus a full move, and the limit.
	localparam int SW = (COORD_BITS + 3 > CFG_W + 1) ? COORD_BITS + 3 : CFG_W + 1;
	localparam logic signed [SW-1:0] COORD_MAX_S = {{(SW-COORD_BITS){1'b0}},
		{COORD_BITS{1'b1}}};

	logic [CFG_W-1:0]      screen_width_q;
	logic [CFG_W-1:0]      screen_height_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	phase_t                phase_q;
	logic [7:0]            header_q;
	logic [7:0]            x_move_q;
	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;
	logic                  out_valid_q;
	logic [OUT_COORD_W-1:0] cursor_x_q;
	logic [OUT_COORD_W-1:0] cursor_y_q;
	logic [2:0]            buttons_q;

	logic                  slot_free;
	logic                  advance;
	logic                  in_fire;
	logic                  cfg_write;
	logic                  finish;
	logic signed [SW-1:0]  x_sum;
	logic signed [SW-1:0]  y_sum;
	logic [COORD_BITS-1:0] pos_x_next;
	logic [COORD_BITS-1:0] pos_y_next;

	function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [SW-1:0] v,
			input logic [CFG_W-1:0] size);
		logic [CFG_W-1:0]     lim_c;
		logic signed [SW-1:0] lim;
		logic [COORD_BITS-1:0] res;
		lim_c = (size == '0) ? '0 : size - 1'b1;
		lim = signed'(SW'(lim_c));
		if (lim > COORD_MAX_S) begin
			lim = COORD_MAX_S;
		end
		if (v < 0) begin
			res = '0;
		end else if (v > lim) begin
			res = lim[COORD_BITS-1:0];
		end else begin
			res = v[COORD_BITS-1:0];
		end
		return res;
	endfunction

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			REG_SCREEN_WIDTH:  prdata = APB_DW'(screen_width_q);
			REG_SCREEN_HEIGHT: prdata = APB_DW'(screen_height_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[CFG_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Only a third byte needs the output register, so other bytes never wait.
	assign slot_free = !out_valid_q || out_ready || (phase_q != PH_YMOVE);
	assign advance   = valid_s1 && slot_free;
	assign in_ready  = !valid_s1 || slot_free;
	assign in_fire   = in_valid && in_ready;
	assign finish    = advance && (phase_q == PH_YMOVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		x_sum = SW'(signed'({1'b0, pos_x_q}))
			+ SW'(movement(x_move_q, header_q[HDR_X_SIGN], header_q[HDR_X_OVF]));
		y_sum = SW'(signed'({1'b0, pos_y_q}))
			- SW'(movement(byte_s1, header_q[HDR_Y_SIGN], header_q[HDR_Y_OVF]));
		pos_x_next = clamp_axis(x_sum, screen_width_q);
		pos_y_next = clamp_axis(y_sum, screen_height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else if (advance) begin
			case (phase_q)
				PH_SKIP: phase_q <= PH_HEADER;
				PH_XMOVE: phase_q <= PH_YMOVE;
				PH_YMOVE: begin
					phase_q <= PH_HEADER;
					pos_x_q <= pos_x_next;
					pos_y_q <= pos_y_next;
				end
				default: begin
					if (byte_s1[HDR_SYNC]) begin
						phase_q <= PH_XMOVE;
					end else begin
						phase_q <= PH_HEADER;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (phase_q == PH_HEADER)) begin
			header_q <= byte_s1;
		end
		if (advance && (phase_q == PH_XMOVE)) begin
			x_move_q <= byte_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			cursor_x_q <= OUT_COORD_W'(pos_x_next);
			cursor_y_q <= OUT_COORD_W'(pos_y_next);
			buttons_q  <= {header_q[HDR_MIDDLE], header_q[HDR_RIGHT], header_q[HDR_LEFT]};
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_x       = cursor_x_q;
	assign cursor_y       = cursor_y_q;
	assign left_pressed   = buttons_q[0];
	assign right_pressed  = buttons_q[1];
	assign middle_pressed = buttons_q[2];

	`PS2MT_ASSERT_NEXT(a_finish_offers_result, clk, arst_n, finish,
		out_valid && (phase_q == PH_HEADER), "completed packet gave no result")
	`PS2MT_ASSERT_NOW(a_stall_only_on_full, clk, arst_n, !in_ready,
		valid_s1 && out_valid_q && !out_ready && (phase_q == PH_YMOVE),
		"input stalled without a pending result")
	`PS2MT_ASSERT_NEXT(a_no_result_without_packet, clk, arst_n, !out_valid_q && !finish,
		!out_valid_q, "result appeared without a completed packet")

endmodule

`default_nettype wire
